FILE: hw/rtl/sitda_pkg.sv
package sitda_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] ASCII_MINUS = 8'd45;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;

    typedef logic [7:0] t_char;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: hw/rtl/sitda_front.sv
module sitda_front #(
    parameter int VALUE_BITS = sitda_pkg::DEF_VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    input  sitda_pkg::t_q_status          i_q_status,
    output logic                          o_push,
    output logic [VALUE_BITS:0]           o_word
);
    import sitda_pkg::*;

    logic                  r_valid, n_valid;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  take;

    // hold the word while the queue is full
    assign busy   = r_valid && i_q_status.full;
    assign take   = start && !busy;
    assign o_push = r_valid && !i_q_status.full;
    assign o_word = {r_neg, r_mag};

    always_comb begin
        n_valid = take || (r_valid && i_q_status.full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (take) begin
            r_neg <= i_value[VALUE_BITS-1];
            r_mag <= i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
        end
    end

endmodule

FILE: hw/rtl/sitda_queue.sv
module sitda_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = sitda_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_word,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_word,
    output sitda_pkg::t_q_status  o_status
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_word         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= bump(r_wr);
            if (i_pop)  r_rd <= bump(r_rd);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
        if (i_push) r_mem[r_wr] <= i_word;
    end

endmodule

FILE: hw/rtl/sitda_back.sv
module sitda_back #(
    parameter int VALUE_BITS = sitda_pkg::DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sitda_pkg::t_q_status  i_q_status,
    input  logic [VALUE_BITS:0]   i_word,
    output logic                  o_pop,
    output logic                  o_strobe,
    output sitda_pkg::t_char      o_char_code,
    output logic                  o_last_char
);
    import sitda_pkg::*;

    // enough decimal digits for 2^VALUE_BITS, one spare at most
    localparam int NDIG   = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W  = NDIG * 4;
    localparam int CNT_W  = $clog2(VALUE_BITS);
    localparam int LEFT_W = $clog2(NDIG);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_TRIM = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_DIGS = 3'd4;

    logic [2:0]            r_state, n_state;
    logic                  r_neg, n_neg;
    logic [VALUE_BITS-1:0] r_sh, n_sh;
    logic [BCD_W-1:0]      r_bcd, n_bcd, bcd_adj;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  n_strobe, n_last;
    t_char                 n_char;
    logic [3:0]            top_dig;

    assign top_dig = r_bcd[BCD_W-1 -: 4];
    assign o_pop   = (r_state == S_IDLE) && !i_q_status.empty;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            bcd_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? r_bcd[d*4 +: 4] + 4'd3
                                                          : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_sh     = r_sh;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_strobe = 1'b0;
        n_char   = ASCII_ZERO;
        n_last   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    n_neg   = i_word[VALUE_BITS];
                    n_sh    = i_word[VALUE_BITS-1:0];
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_sh[VALUE_BITS-1]};
                n_sh  = {r_sh[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                    n_left  = LEFT_W'(NDIG - 1);
                    n_state = S_TRIM;
                end
            end
            S_TRIM: begin
                if (top_dig == 4'd0 && r_left != '0) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left = r_left - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_DIGS;
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_char   = ASCII_MINUS;
                n_state  = S_DIGS;
            end
            S_DIGS: begin
                n_strobe = 1'b1;
                n_char   = ASCII_ZERO + {4'd0, top_dig};
                n_last   = (r_left == '0);
                n_bcd    = {r_bcd[BCD_W-5:0], 4'd0};
                n_left   = r_left - 1'b1;
                if (r_left == '0) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= n_strobe;
        end
        r_neg       <= n_neg;
        r_sh        <= n_sh;
        r_bcd       <= n_bcd;
        r_cnt       <= n_cnt;
        r_left      <= n_left;
        o_char_code <= n_char;
        o_last_char <= n_last;
    end

endmodule

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text.
//
// Input: drive i_value and raise start; the word is taken at a rising edge
// where start is high and busy is low. busy rises only when the front
// register holds a word and the two-word queue behind it is full.
// Output: each character is shown for one cycle with o_strobe high, most
// significant first: a leading minus (45) for negative values, then digits
// 48 to 57 without leading zeros. o_last_char marks the final character.
// The receiver cannot stall; characters leave at one per cycle.
// Steps per word (NDIG = 10 digit slots at VALUE_BITS = 32): the front
// register, the queue, a pop into the back part when it is idle, the
// bit-serial shift-add-three conversion over all VALUE_BITS bits, then
// the dropping of leading zeros and the digits, led by a minus sign if
// negative. The back part pops the next word only once it is idle again
// after the last character of a word; the bit-serial converter sets the
// pace; the queue lets the front take new words while a conversion runs.
// Reset (synchronous, active low) empties the front register and queue and
// returns the back part to idle; no character is in flight afterwards.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sitda_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_strobe,
    output sitda_pkg::t_char             o_char_code,
    output logic                         o_last_char
);
    import sitda_pkg::*;

    t_q_status             q_status;
    logic                  push, pop;
    logic [VALUE_BITS:0]   push_word, pop_word;

    // front: take the word, form sign and magnitude
    sitda_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_q_status (q_status),
        .o_push     (push),
        .o_word     (push_word)
    );

    // decouple front and back
    sitda_queue #(.WIDTH(VALUE_BITS + 1), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (push_word),
        .i_pop    (pop),
        .o_word   (pop_word),
        .o_status (q_status)
    );

    // back: convert to BCD, drop leading zeros, emit characters
    sitda_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_word      (pop_word),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import sitda_pkg::*;

    localparam int VB            = DEF_VALUE_BITS;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 350;
    localparam int QUIET_TAIL    = 40;    // last words go in back to back
    localparam int SETTLE_CYCLES = 80;    // outlasts the longest word
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 30;

    localparam logic [VB-1:0] RADIX = 10;

    // One character as it leaves the block.
    typedef struct {
        t_char code;
        logic  last;
    } t_char_item;

    // One directed word; an empty text means the predictor supplies the
    // expectation.
    typedef struct {
        logic [VB-1:0] value;
        string         text;
    } t_directed_row;

    localparam int N_DIRECTED = 22;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic [VB-1:0] i_value = '0;
    logic          busy;
    logic          o_strobe;
    t_char         o_char_code;
    logic          o_last_char;

    t_char_item pending_chars[$];
    int         words_sent    = 0;
    int         chars_checked = 0;
    int         error_count   = 0;
    int         cycle_count   = 0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{32'd0,          "0"},
        '{32'd1,          "1"},
        '{-32'sd1,        "-1"},
        '{32'd9,          "9"},
        '{32'd10,         "10"},
        '{-32'sd10,       "-10"},
        '{32'h7FFF_FFFF,  "2147483647"},
        '{32'h8000_0000,  "-2147483648"},
        '{32'h8000_0001,  ""},
        '{-32'sd9,        ""},
        '{32'd99,         ""},
        '{32'd100,        ""},
        '{32'd999999999,  ""},
        '{32'd1000000000, ""},
        '{-32'sd999999999, ""},
        '{-32'sd1000000000, ""},
        '{32'd123456789,  ""},
        '{32'h5555_5555,  ""},
        '{32'hAAAA_AAAA,  ""},
        '{32'd1000000009, ""},
        '{32'hFFFF_FFF6,  ""},
        '{32'd0,          "0"}
    };

    signed_int_to_decimal_ascii #(
        .VALUE_BITS(VB)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .o_strobe   (o_strobe),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    always #2 i_clk = ~i_clk;

    // Work out the decimal text of one word and queue its characters:
    // optional minus, then digits from the most significant, no leading
    // zeros, last flag on the final digit. The magnitude is taken as an
    // unsigned number, so the most negative word needs no special handling.
    function automatic void queue_decimal_text(input logic [VB-1:0] word);
        logic [VB-1:0] mag;
        t_char         rev [0:19];
        int            ndig;
        logic          neg;
        t_char_item    item;
        neg  = word[VB-1];
        mag  = neg ? (~word + 1'b1) : word;
        ndig = 0;
        do begin
            rev[ndig] = ASCII_ZERO + t_char'(mag % RADIX);
            ndig++;
            mag = mag / RADIX;
        end while (mag != 0);
        if (neg) begin
            item.code = ASCII_MINUS;
            item.last = 1'b0;
            pending_chars.push_back(item);
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            item.code = rev[k];
            item.last = (k == 0);
            pending_chars.push_back(item);
        end
    endfunction

    // Queue characters typed straight into the directed table.
    function automatic void queue_typed_text(input string text);
        t_char_item item;
        for (int k = 0; k < text.len(); k++) begin
            item.code = t_char'(text[k]);
            item.last = (k == text.len() - 1);
            pending_chars.push_back(item);
        end
    endfunction

    // Draw a word with a spread of digit counts: full random (every bit
    // toggles), short magnitudes, magnitudes of up to a chosen length, words
    // close to the ends of the range, and magnitudes next to a power of ten.
    function automatic logic [VB-1:0] random_word();
        logic [63:0]   span;
        logic [VB-1:0] mag;
        logic          neg;
        int            ndig;
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0: mag = $urandom_range(0, 99);
            1: begin
                ndig = $urandom_range(1, 10);
                span = 1;
                repeat (ndig) span = span * 10;
                mag  = VB'(64'($urandom) % span);
            end
            2: mag = 32'h7FFF_FFFF - $urandom_range(0, 20);
            3: begin
                // step across a power of ten
                span = 1;
                repeat ($urandom_range(1, 9)) span = span * 10;
                mag  = VB'(span) + $urandom_range(0, 2) - 1;
            end
            default: return $urandom;
        endcase
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    // Offer one word and hold it until the block takes it. A nonzero gap
    // first lowers start and puts noise on the data bus while it lasts.
    task automatic send_word(input logic [VB-1:0] word, input int gap);
        if (gap > 0) begin
            start   <= 1'b0;
            i_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= word;
        do @(posedge i_clk); while (busy !== 1'b0);
        words_sent++;
    endtask

    // Drop start and hold off until every queued character has arrived.
    task automatic hold_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_chars.size() != 0);
    endtask

    // Check every strobed character against the oldest expectation.
    always @(posedge i_clk) begin
        t_char_item want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected character: expected none, actual code %0d last %b",
                             $realtime, o_char_code, o_last_char);
            end else begin
                want = pending_chars.pop_front();
                if (o_strobe !== 1'b1 || o_char_code !== want.code
                        || o_last_char !== want.last) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: expected code %0d last %b, actual code %0d last %b strobe %b",
                                 $realtime, want.code, want.last, o_char_code,
                                 o_last_char, o_strobe);
                end
            end
        end
    end

    // Abandon a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d characters still expected",
                     $realtime, cycle_count, pending_chars.size());
            $display("FAIL signed_int_to_decimal_ascii");
            $finish;
        end
    end

    initial begin
        int            gap;
        logic [VB-1:0] word;

        // Hold reset, then release it once.
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: extremes, sign changes, digit-count boundaries.
        // Every third row goes in with a short gap, the rest back to back.
        for (int r = 0; r < N_DIRECTED; r++) begin
            gap = (r % 3 == 2) ? $urandom_range(1, 9) : 0;
            send_word(directed_rows[r].value, gap);
            if (directed_rows[r].text.len() != 0)
                queue_typed_text(directed_rows[r].text);
            else
                queue_decimal_text(directed_rows[r].value);
        end
        hold_until_drained();

        // Random words. Idling comes and goes in stretches of 50 words and
        // stops for the tail; halfway through, let the block run dry once.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            word = random_word();
            if (n < RANDOM_WORDS - QUIET_TAIL && (n / 50) % 2 == 0
                    && $urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 9);
            else
                gap = 0;
            send_word(word, gap);
            queue_decimal_text(word);
            if (n == RANDOM_WORDS / 2)
                hold_until_drained();
        end

        // Wait for the last characters, then allow for anything stray.
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Converted %0d words (directed extremes plus random lengths and signs),",
                 words_sent);
        $display("checked %0d characters, %0d mismatches.", chars_checked, error_count);
        if (error_count == 0 && pending_chars.size() == 0) begin
            $display("PASS signed_int_to_decimal_ascii");
        end else begin
            $display("FAIL signed_int_to_decimal_ascii");
        end
        $finish;
    end

endmodule
